FILE: hdl/scrtok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer package
// Shared widths, character codes, token kinds, lexer modes and helpers.
// ----------------------------------------------------------------------------
package scrtok_pkg;

    // Internal position width and width of the token fields on the port
    localparam int POS_BITS = 16;
    localparam int TOKEN_W  = 16;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Token kinds
    localparam logic [1:0] KIND_NUMBER   = 2'd0;
    localparam logic [1:0] KIND_SYMBOL   = 2'd1;
    localparam logic [1:0] KIND_STRING   = 2'd2;
    localparam logic [1:0] KIND_VARIABLE = 2'd3;

    // Lexer modes
    typedef enum logic [4:0] {
        MODE_SPACE   = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_STRING  = 5'b00100,
        MODE_NUMBER  = 5'b01000,
        MODE_SYMBOL  = 5'b10000
    } mode_t;

    // Token descriptor
    typedef struct packed {
        logic [1:0]         kind;
        logic [TOKEN_W-1:0] start;
        logic [TOKEN_W-1:0] length;
    } token_t;

    // Increment a position, holding at the top value
    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // Digit or decimal point
    function automatic logic is_num_char(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
    endfunction

endpackage

FILE: hdl/scrtok_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer text channel
// Valid/ready channel carrying one text byte and the start-of-text flag.
// ----------------------------------------------------------------------------
interface scrtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_of_text;

    modport source (output valid, output ch, output start_of_text, input ready);
    modport sink   (input valid, input ch, input start_of_text, output ready);
endinterface

FILE: hdl/scrtok_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer token channel
// Valid/ready channel carrying one token descriptor.
// ----------------------------------------------------------------------------
interface scrtok_out_if
    import scrtok_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         token_kind;
    logic [TOKEN_W-1:0] token_start;
    logic [TOKEN_W-1:0] token_length;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, output ready);
endinterface

FILE: hdl/script_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer unit
// Byte-serial lexer emitting token descriptors for a small script language.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle and returns one token descriptor (kind, start
// offset, length) from its output register after the closing byte; a byte
// is accepted every cycle while the output side keeps up. While a token waits
// at the output, bytes keep flowing until a second token closes; that token is
// held in the buffer's second entry and input stalls until the first is taken.
// Raise start_of_text with the first byte of each text: it restarts the offset
// at zero and drops any token left open by the previous text. Offsets stop at
// their maximum value. Kinds: 0 number, 1 symbol, 2 string, 3 variable.
module script_tokenizer_unit
    import scrtok_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    scrtok_in_if.sink      text,
    scrtok_out_if.source   token
);

    logic   accept;
    logic   tok_valid;
    token_t tok;
    logic   buf_ready;
    token_t out_tok;

    // Take an item whenever the buffer has room
    assign text.ready = buf_ready;
    assign accept     = text.valid && buf_ready;

    scrtok_lexer u_lexer (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .ch            (text.ch),
        .start_of_text (text.start_of_text),
        .tok_valid     (tok_valid),
        .tok           (tok)
    );

    scrtok_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tok_valid),
        .push_tok  (tok),
        .in_ready  (buf_ready),
        .out_valid (token.valid),
        .out_ready (token.ready),
        .out_tok   (out_tok)
    );

    assign token.token_kind   = out_tok.kind;
    assign token.token_start  = out_tok.start;
    assign token.token_length = out_tok.length;

endmodule

FILE: hdl/scrtok_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer lexer core
// Holds mode, position and pending token start; classifies each byte and
// produces a token descriptor in the cycle the closing byte is taken.
// ----------------------------------------------------------------------------
module scrtok_lexer
    import scrtok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] ch,
    input  logic       start_of_text,
    output logic       tok_valid,
    output token_t     tok
);

    mode_t               mode_reg, mode_next, mode_cur;
    logic [POS_BITS-1:0] pos_reg, pos_cur;
    logic [POS_BITS-1:0] pstart_reg, pstart_next, pstart_cur;
    logic                minus_reg, minus_next, minus_cur;
    logic [7:0]          c;
    logic                closer;
    logic                emit;
    logic [1:0]          kind;
    logic [POS_BITS-1:0] diff;
    logic [POS_BITS-1:0] len;

    // Fold bracket, tab and newline bytes into spaces
    always_comb
    begin
        if ((ch == CH_LBRACK) || (ch == CH_LPAREN) || (ch == CH_RBRACK) ||
            (ch == CH_RPAREN) || (ch == CH_TAB) || (ch == CH_NL))
            c = CH_SPACE;
        else
            c = ch;
    end

    // Drop the old text state on start of text
    always_comb
    begin
        mode_cur   = start_of_text ? MODE_SPACE : mode_reg;
        pos_cur    = start_of_text ? '0 : pos_reg;
        pstart_cur = start_of_text ? '0 : pstart_reg;
        minus_cur  = start_of_text ? 1'b0 : minus_reg;
    end

    assign closer = (c == CH_COLON) || (c == CH_HASH) || (c == CH_SPACE);
    assign diff   = pos_cur - pstart_cur;

    // Mode transition and token close
    always_comb
    begin
        mode_next   = mode_cur;
        pstart_next = pstart_cur;
        minus_next  = minus_cur;
        emit        = 1'b0;
        kind        = KIND_NUMBER;
        len         = '0;
        unique case (mode_cur) inside
            MODE_SPACE:
            begin
                if (c == CH_SPACE)
                begin
                    mode_next = MODE_SPACE;
                end
                else if (c == CH_HASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next   = MODE_STRING;
                    pstart_next = sat_inc(pos_cur);
                end
                else if (is_num_char(c) || (c == CH_MINUS))
                begin
                    mode_next   = MODE_NUMBER;
                    pstart_next = pos_cur;
                    minus_next  = (c == CH_MINUS);
                end
                else
                begin
                    mode_next   = MODE_SYMBOL;
                    pstart_next = pos_cur;
                end
            end
            MODE_COMMENT:
            begin
                if (ch == CH_NL)
                    mode_next = MODE_SPACE;
            end
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    emit      = 1'b1;
                    kind      = KIND_STRING;
                    len       = (pos_cur >= pstart_cur) ? diff : '0;
                    mode_next = MODE_SPACE;
                end
            end
            MODE_NUMBER, MODE_SYMBOL:
            begin
                kind = (mode_cur == MODE_NUMBER) ? KIND_NUMBER : KIND_SYMBOL;
                if ((mode_cur == MODE_NUMBER) && !closer && !is_num_char(c))
                begin
                    mode_next = MODE_SYMBOL;
                    kind      = KIND_SYMBOL;
                end
                if (closer)
                begin
                    if (c == CH_COLON)
                        kind = KIND_VARIABLE;
                    if (pos_cur != pstart_cur)
                    begin
                        len = (pos_cur > pstart_cur) ? diff : '0;
                        // a lone minus sign is a symbol
                        if ((kind == KIND_NUMBER) && (len == POS_BITS'(1)) && minus_cur)
                            kind = KIND_SYMBOL;
                        emit = 1'b1;
                    end
                    mode_next = (c == CH_HASH) ? MODE_COMMENT : MODE_SPACE;
                end
            end
            default:
            begin
                mode_next = MODE_SPACE;
            end
        endcase
    end

    // Advance lexer state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SPACE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            minus_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= sat_inc(pos_cur);
            pstart_reg <= pstart_next;
            minus_reg  <= minus_next;
        end
    end

    // Present the closed token
    assign tok_valid  = accept && emit;
    assign tok.kind   = kind;
    assign tok.start  = TOKEN_W'(pstart_cur);
    assign tok.length = TOKEN_W'(len);

    // A closed string always returns to space mode
    a_string_to_space: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (tok.kind == KIND_STRING)) |=> (mode_reg == MODE_SPACE))
        else $error("string close did not return to space mode");

    // Every accepted byte leaves a non-zero position behind it
    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pos_reg != '0))
        else $error("position did not advance");

    // Position holds without an accepted byte
    a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pos_reg))
        else $error("position moved without an item");

endmodule

FILE: hdl/scrtok_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer output buffer
// Output register plus one skid entry so the input side keeps flowing
// while a token waits to be taken.
// ----------------------------------------------------------------------------
module scrtok_out_buf
    import scrtok_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_tok,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    token_t out_tok_reg, out_tok_next;
    token_t skid_tok_reg, skid_tok_next;
    logic   take;

    assign take = out_valid_reg && out_ready;

    // Route pushed tokens to the output register or the skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_tok_next    = out_tok_reg;
        skid_tok_next   = skid_tok_reg;
        if (take)
        begin
            out_valid_next = skid_valid_reg;
            out_tok_next   = skid_tok_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_tok_next   = push_tok;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_tok_next   = push_tok;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        skid_tok_reg <= skid_tok_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

    // The skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // No push while the skid entry is occupied
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("token pushed into a full buffer");

    // A taken token with nothing behind it empties the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !skid_valid_reg && !push) |=> !out_valid_reg)
        else $error("output stayed valid after drain");

endmodule

FILE: bench/token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer token checker
// Watches both channels, runs a byte-level lexer of its own on every accepted
// text item and compares each accepted token item, field by field, with the
// oldest predicted token. Hands the error count and the number of tokens still
// awaited to the testbench top.
// ----------------------------------------------------------------------------
module token_checker
    import scrtok_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    scrtok_in_if  text,
    scrtok_out_if token,
    output int    mismatches,
    output int    outstanding
);

    // Lexer state of the predictor
    mode_t               lex_state;
    logic [POS_BITS-1:0] cur_pos;
    logic [POS_BITS-1:0] tok_begin;
    logic                minus_first;

    token_t              expected_tokens[$];
    token_t              want;
    token_t              got;
    bit                  made;

    // Step a position, holding at the top value
    function automatic logic [POS_BITS-1:0] pos_next(input logic [POS_BITS-1:0] p);
        if (p == POS_MAX)
            return p;
        return p + 1'b1;
    endfunction

    function automatic bit digit_or_dot(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
    endfunction

    // Lex one byte; return 1 with the closed token in tok when one closes
    function automatic bit lex_byte(input logic [7:0] raw, input logic sot,
                                    output token_t tok);
        logic [7:0]          c;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] len;
        logic [1:0]          kind;
        bit                  closer;
        bit                  emit;

        emit = 1'b0;
        tok  = '0;

        // Restart the text before this byte
        if (sot)
        begin
            lex_state   = MODE_SPACE;
            cur_pos     = '0;
            tok_begin   = '0;
            minus_first = 1'b0;
        end

        // Brackets, parentheses, tab and newline act as spaces
        c = raw;
        if (raw == CH_LBRACK || raw == CH_RBRACK || raw == CH_LPAREN ||
            raw == CH_RPAREN || raw == CH_TAB || raw == CH_NL)
            c = CH_SPACE;

        pos = cur_pos;

        case (lex_state)
            MODE_COMMENT:
            begin
                // Only a raw newline ends a comment
                if (raw == CH_NL)
                    lex_state = MODE_SPACE;
            end
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    len        = (pos >= tok_begin) ? pos - tok_begin : '0;
                    tok.kind   = KIND_STRING;
                    tok.start  = TOKEN_W'(tok_begin);
                    tok.length = TOKEN_W'(len);
                    emit       = 1'b1;
                    lex_state  = MODE_SPACE;
                end
            end
            MODE_NUMBER, MODE_SYMBOL:
            begin
                closer = (c == CH_COLON) || (c == CH_HASH) || (c == CH_SPACE);
                kind   = (lex_state == MODE_NUMBER) ? KIND_NUMBER : KIND_SYMBOL;
                // A non-numeric character turns a number into a symbol
                if (lex_state == MODE_NUMBER && !closer && !digit_or_dot(c))
                begin
                    lex_state = MODE_SYMBOL;
                    kind      = KIND_SYMBOL;
                end
                if (closer)
                begin
                    if (c == CH_COLON)
                        kind = KIND_VARIABLE;
                    // Nothing to report when start and close share a held position
                    if (pos != tok_begin)
                    begin
                        len = (pos > tok_begin) ? pos - tok_begin : '0;
                        if (kind == KIND_NUMBER && len == 1 && minus_first)
                            kind = KIND_SYMBOL;
                        tok.kind   = kind;
                        tok.start  = TOKEN_W'(tok_begin);
                        tok.length = TOKEN_W'(len);
                        emit       = 1'b1;
                    end
                    lex_state = (c == CH_HASH) ? MODE_COMMENT : MODE_SPACE;
                end
            end
            default:
            begin
                // Space mode: open whatever the byte begins
                if (c == CH_HASH)
                    lex_state = MODE_COMMENT;
                else if (c == CH_QUOTE)
                begin
                    lex_state = MODE_STRING;
                    tok_begin = pos_next(pos);
                end
                else if (digit_or_dot(c) || c == CH_MINUS)
                begin
                    lex_state   = MODE_NUMBER;
                    tok_begin   = pos;
                    minus_first = (c == CH_MINUS);
                end
                else if (c != CH_SPACE)
                begin
                    lex_state = MODE_SYMBOL;
                    tok_begin = pos;
                end
            end
        endcase

        cur_pos = pos_next(pos);
        return emit;
    endfunction

    // Predict on text items, compare on token items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_state   = MODE_SPACE;
            cur_pos     = '0;
            tok_begin   = '0;
            minus_first = 1'b0;
            expected_tokens.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                made = lex_byte(text.ch, text.start_of_text, want);
                if (made)
                    expected_tokens.push_back(want);
            end

            if (token.valid && token.ready)
            begin
                got.kind   = token.token_kind;
                got.start  = token.token_start;
                got.length = token.token_length;
                if (expected_tokens.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected token: expected none, %s %0d %0d %0d",
                             $time, "actual kind/start/length",
                             got.kind, got.start, got.length);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (want.kind != got.kind || want.start != got.start ||
                        want.length != got.length)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: token mismatch: expected kind %0d start %0d length %0d,",
                                 $time, want.kind, want.start, want.length);
                        $display("%0t:   actual kind %0d start %0d length %0d",
                                 $time, got.kind, got.start, got.length);
                    end
                end
            end

            outstanding <= expected_tokens.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer testbench
// Drives text items into the tokenizer: a short directed text, a stalled-output
// burst, mixed tokens, then random fragments with random start-of-text restarts.
// Both sides idle in random bursts; the token checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
    import scrtok_pkg::*;
;

    localparam int RANDOM_ITEMS  = 1650;
    localparam int QUIET_TAIL    = 200;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;

    int   token_errors;
    int   tokens_pending;
    int   items_sent;
    bit   src_idle_on;
    bit   sink_idle_on;
    bit   hold_req;
    bit   hold_active;
    bit   next_sot;

    scrtok_in_if  text_ch ();
    scrtok_out_if token_ch ();

    script_tokenizer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .token (token_ch)
    );

    token_checker tok_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text_ch),
        .token       (token_ch),
        .mismatches  (token_errors),
        .outstanding (tokens_pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pick one character of a set at random
    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Offer one text item, maybe after an idle burst, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 9) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.ch            <= b;
        text_ch.start_of_text <= next_sot;
        next_sot = 1'b0;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Stop offering and wait until every predicted token has arrived or the limit runs out
    task automatic drain(input int limit);
        int waited;
        waited = 0;
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (tokens_pending != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // One random piece of script: mostly well-formed, some noise
    task automatic send_fragment();
        int         sel;
        int         n;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 22)
        begin
            if ($urandom_range(0, 2) == 0)
                send_byte(CH_MINUS);
            n = $urandom_range(0, 5);
            repeat (n) send_byte(pick_char("0123456789."));
        end
        else if (sel < 40)
        begin
            n = $urandom_range(1, 5);
            repeat (n) send_byte(pick_char("abcxyz_+*/<=>!?XYZ"));
        end
        else if (sel < 52)
        begin
            send_byte(CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE)
                    b = "q";
                send_byte(b);
            end
            send_byte(CH_QUOTE);
        end
        else if (sel < 60)
        begin
            send_byte(CH_HASH);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_NL)
                    b = CH_TAB;
                send_byte(b);
            end
            send_byte(CH_NL);
        end
        else if (sel < 80)
            send_byte(pick_char(" \t\n[]()"));
        else if (sel < 88)
            send_byte(CH_COLON);
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Token receiver: random stalls, one long hold-off on request
    initial
    begin
        token_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                token_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_active = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                token_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                token_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n                 = 1'b0;
        text_ch.valid         = 1'b0;
        text_ch.ch            = '0;
        text_ch.start_of_text = 1'b0;
        src_idle_on           = 1'b1;
        sink_idle_on          = 1'b1;
        hold_req              = 1'b0;
        hold_active           = 1'b0;
        next_sot              = 1'b0;
        items_sent            = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone minus, variable, number into comment, empty string,
        // high byte in a symbol, number turned symbol, open string dropped
        next_sot = 1'b1;
        send_text("- -12:3.5#x\n(\"\"a");
        send_byte(8'hFF);
        send_text(") 1a [\"q");
        next_sot = 1'b1;
        send_text("z\t");
        send_byte(8'h00);
        send_byte(CH_RBRACK);

        // Pause the sender until all tokens are in
        drain(DRAIN_LIMIT);

        // Hold the receiver off while tokens keep coming
        hold_req = 1'b1;
        while (!hold_active)
            @(posedge clk);
        repeat (20) send_text("k ");
        drain(DRAIN_LIMIT);

        // Mixed tokens with empty and short strings and a variable
        send_text("abcdefg \"\" 7 ab \"x\" q:");
        repeat (40) send_fragment();
        drain(DRAIN_LIMIT);

        // Random fragments, quiet on both sides towards the end
        next_sot = 1'b1;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if ($urandom_range(0, 59) == 0)
                next_sot = 1'b1;
            send_fragment();
        end

        drain(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (token_errors == 0 && tokens_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/scrtok_pkg.sv
hdl/scrtok_in_if.sv
hdl/scrtok_out_if.sv
hdl/scrtok_lexer.sv
hdl/scrtok_out_buf.sv
hdl/script_tokenizer_unit.sv
bench/token_checker.sv
bench/tb_top.sv
